// ----- rtl/rds_pkg.sv -----
`default_nettype none
package rds_pkg;

    localparam int INDEX_BITS = 10;
    localparam int REG_BITS   = 32;
    localparam int NUM_REGS   = 6;
    localparam int IDX_W      = 3;

    // product of one register and one index
    localparam int PROD_BITS  = REG_BITS + INDEX_BITS;
    // three-term sum and its magnitude
    localparam int Q_BITS     = PROD_BITS + 2;
    localparam int MAG_BITS   = Q_BITS - 1;
    localparam int HALF_BITS  = (MAG_BITS + 1) / 2;
    localparam int HI_BITS    = MAG_BITS - HALF_BITS;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int SAT_BIT    = 88;
    localparam int SHIFT      = 24;
    localparam int EXT_BITS   = (SUM_BITS > SAT_BIT + 1) ? SUM_BITS : SAT_BIT + 1;
    localparam int RAD_BITS   = SAT_BIT - SHIFT;
    localparam int ROOT_BITS  = 32;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int DREM_BITS  = ROOT_BITS + 1;

    localparam logic [ROOT_BITS-1:0] ALL_ONES   = '1;
    localparam logic [ROOT_BITS-1:0] MIN_RECIP  = 32'd64;
    localparam logic [DREM_BITS-1:0] INIT_REM   = 33'd64;
    localparam logic [REG_BITS-1:0]  ONE_Q2_30  = 32'h4000_0000;

    localparam logic [IDX_W-1:0] REG_B00 = 3'd0;
    localparam logic [IDX_W-1:0] REG_B01 = 3'd1;
    localparam logic [IDX_W-1:0] REG_B02 = 3'd2;
    localparam logic [IDX_W-1:0] REG_B11 = 3'd3;
    localparam logic [IDX_W-1:0] REG_B12 = 3'd4;
    localparam logic [IDX_W-1:0] REG_B22 = 3'd5;

    typedef logic signed [REG_BITS-1:0] coef_t;

    typedef struct packed {
        coef_t b00;
        coef_t b01;
        coef_t b02;
        coef_t b11;
        coef_t b12;
        coef_t b22;
    } bmat_t;

    typedef struct packed {
        logic                valid;
        logic                sat;
        logic [RAD_BITS-1:0] rad;
    } radicand_t;

    typedef struct packed {
        logic                 valid;
        logic [ROOT_BITS-1:0] recip;
    } root_t;

endpackage
`default_nettype wire

// ----- rtl/rds_sqsum.sv -----
`default_nettype none
// Q = B*hkl and |Q|^2, five register stages.
module rds_sqsum
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    en,
    input  wire logic                                    valid,
    input  wire logic signed [rds_pkg::INDEX_BITS-1:0]   index_h,
    input  wire logic signed [rds_pkg::INDEX_BITS-1:0]   index_k,
    input  wire logic signed [rds_pkg::INDEX_BITS-1:0]   index_l,
    input  wire rds_pkg::bmat_t                          bmat,
    output rds_pkg::radicand_t                           rad
);

    logic                                   v_reg [0:4];
    logic signed [rds_pkg::PROD_BITS-1:0]   p_reg [0:5];
    logic [rds_pkg::MAG_BITS-1:0]           mag_reg [0:2];
    logic [2*rds_pkg::HALF_BITS-1:0]        ll_reg [0:2];
    logic [2*rds_pkg::HI_BITS-1:0]          hh_reg [0:2];
    logic [rds_pkg::MAG_BITS-1:0]           hl_reg [0:2];
    logic [rds_pkg::SQ_BITS-1:0]            sq_reg [0:2];
    logic [rds_pkg::EXT_BITS-1:0]           sum_reg;

    logic signed [rds_pkg::Q_BITS-1:0]      q_next [0:2];
    logic [rds_pkg::SUM_BITS-1:0]           sum_next;

    always_comb
    begin
        q_next[0] = rds_pkg::Q_BITS'(p_reg[0]) + rds_pkg::Q_BITS'(p_reg[1])
                  + rds_pkg::Q_BITS'(p_reg[2]);
        q_next[1] = rds_pkg::Q_BITS'(p_reg[3]) + rds_pkg::Q_BITS'(p_reg[4]);
        q_next[2] = rds_pkg::Q_BITS'(p_reg[5]);
        sum_next  = rds_pkg::SUM_BITS'(sq_reg[0]) + rds_pkg::SUM_BITS'(sq_reg[1])
                  + rds_pkg::SUM_BITS'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= valid;
            for (int i = 1; i < 5; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= $signed(bmat.b00) * index_h;
            p_reg[1] <= $signed(bmat.b01) * index_k;
            p_reg[2] <= $signed(bmat.b02) * index_l;
            p_reg[3] <= $signed(bmat.b11) * index_k;
            p_reg[4] <= $signed(bmat.b12) * index_l;
            p_reg[5] <= $signed(bmat.b22) * index_l;
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= q_next[i][rds_pkg::Q_BITS-1]
                              ? rds_pkg::MAG_BITS'(-q_next[i])
                              : rds_pkg::MAG_BITS'(q_next[i]);
                // split square: hi/lo halves
                ll_reg[i] <= mag_reg[i][rds_pkg::HALF_BITS-1:0]
                           * mag_reg[i][rds_pkg::HALF_BITS-1:0];
                hh_reg[i] <= mag_reg[i][rds_pkg::MAG_BITS-1:rds_pkg::HALF_BITS]
                           * mag_reg[i][rds_pkg::MAG_BITS-1:rds_pkg::HALF_BITS];
                hl_reg[i] <= mag_reg[i][rds_pkg::MAG_BITS-1:rds_pkg::HALF_BITS]
                           * mag_reg[i][rds_pkg::HALF_BITS-1:0];
                sq_reg[i] <= (rds_pkg::SQ_BITS'(hh_reg[i]) << (2*rds_pkg::HALF_BITS))
                           + (rds_pkg::SQ_BITS'(hl_reg[i]) << (rds_pkg::HALF_BITS+1))
                           + rds_pkg::SQ_BITS'(ll_reg[i]);
            end
            sum_reg <= rds_pkg::EXT_BITS'(sum_next);
        end
    end

    // Q.60 -> Q.36 radicand, saturate at 2^88
    assign rad.valid = v_reg[4];
    assign rad.sat   = |sum_reg[rds_pkg::EXT_BITS-1:rds_pkg::SAT_BIT];
    assign rad.rad   = sum_reg[rds_pkg::SAT_BIT-1:rds_pkg::SHIFT];

endmodule
`default_nettype wire

// ----- rtl/rds_sqrt.sv -----
`default_nettype none
// Restoring integer square root, one root bit per stage.
module rds_sqrt
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire rds_pkg::radicand_t  rad,
    output rds_pkg::root_t           root
);

    localparam int N = rds_pkg::ROOT_BITS;

    logic                           v_reg [0:N-1];
    logic                           s_reg [0:N-1];
    logic [rds_pkg::REM_BITS-1:0]   r_reg [0:N-1];
    logic [N-1:0]                   q_reg [0:N-1];
    logic [rds_pkg::RAD_BITS-1:0]   x_reg [0:N-1];

    for (genvar s = 0; s < N; s++)
    begin : g_step
        logic                           v_in;
        logic                           s_in;
        logic [rds_pkg::REM_BITS-1:0]   r_in;
        logic [N-1:0]                   q_in;
        logic [rds_pkg::RAD_BITS-1:0]   x_in;
        logic [rds_pkg::REM_BITS-1:0]   rp;
        logic [rds_pkg::REM_BITS-1:0]   d;
        logic                           ge;

        if (s == 0)
        begin : g_first
            assign v_in = rad.valid;
            assign s_in = rad.sat;
            assign r_in = '0;
            assign q_in = '0;
            assign x_in = rad.rad;
        end
        else
        begin : g_next
            assign v_in = v_reg[s-1];
            assign s_in = s_reg[s-1];
            assign r_in = r_reg[s-1];
            assign q_in = q_reg[s-1];
            assign x_in = x_reg[s-1];
        end

        assign rp = {r_in[rds_pkg::REM_BITS-3:0], x_in[rds_pkg::RAD_BITS-1 -: 2]};
        assign d  = {q_in, 2'b01};
        assign ge = (rp >= d);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[s] <= s_in;
                r_reg[s] <= ge ? (rp - d) : rp;
                q_reg[s] <= {q_in[N-2:0], ge};
                x_reg[s] <= {x_in[rds_pkg::RAD_BITS-3:0], 2'b00};
            end
        end
    end

    assign root.valid = v_reg[N-1];
    assign root.recip = s_reg[N-1] ? rds_pkg::ALL_ONES : q_reg[N-1];

endmodule
`default_nettype wire

// ----- rtl/rds_div.sv -----
`default_nettype none
// 2^38 / recip, restoring, one quotient bit per stage.
module rds_div
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire rds_pkg::root_t                  root,
    output logic                                 valid,
    output logic [rds_pkg::ROOT_BITS-1:0]        recip_spacing,
    output logic [rds_pkg::ROOT_BITS-1:0]        spacing,
    output logic                                 spacing_invalid
);

    localparam int N = rds_pkg::ROOT_BITS;

    logic                           v_reg   [0:N-1];
    logic                           bad_reg [0:N-1];
    logic [rds_pkg::DREM_BITS-1:0]  r_reg   [0:N-1];
    logic [N-1:0]                   d_reg   [0:N-1];
    logic [N-1:0]                   q_reg   [0:N-1];

    for (genvar s = 0; s < N; s++)
    begin : g_step
        logic                           v_in;
        logic                           bad_in;
        logic [rds_pkg::DREM_BITS-1:0]  r_in;
        logic [N-1:0]                   d_in;
        logic [N-1:0]                   q_in;
        logic [rds_pkg::DREM_BITS-1:0]  rs;
        logic [rds_pkg::DREM_BITS-1:0]  dx;
        logic                           ge;

        if (s == 0)
        begin : g_first
            // upper quotient bits are zero for any divisor above 64
            assign v_in   = root.valid;
            assign bad_in = (root.recip <= rds_pkg::MIN_RECIP);
            assign r_in   = rds_pkg::INIT_REM;
            assign d_in   = root.recip;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign v_in   = v_reg[s-1];
            assign bad_in = bad_reg[s-1];
            assign r_in   = r_reg[s-1];
            assign d_in   = d_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        assign rs = {r_in[rds_pkg::DREM_BITS-2:0], 1'b0};
        assign dx = {1'b0, d_in};
        assign ge = (rs >= dx);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                bad_reg[s] <= bad_in;
                r_reg[s]   <= ge ? (rs - dx) : rs;
                d_reg[s]   <= d_in;
                q_reg[s]   <= {q_in[N-2:0], ge};
            end
        end
    end

    assign valid           = v_reg[N-1];
    assign recip_spacing   = d_reg[N-1];
    assign spacing         = bad_reg[N-1] ? rds_pkg::ALL_ONES : q_reg[N-1];
    assign spacing_invalid = bad_reg[N-1];

endmodule
`default_nettype wire

// ----- rtl/reflection_d_spacing_unit.sv -----
// channel | valid     | stall     | payload
// req     | req_valid | req_stall | index_h, index_k, index_l
// rsp     | rsp_valid | rsp_stall | recip_spacing, spacing, spacing_invalid
// cfg     | wr_en     | -         | wr_index, wr_data
//
// One hkl beat per cycle while req_stall is low; each beat passes through the product
// and square sum, the root (one bit per stage) and the reciprocal divide.
// Reset (rst_n, async low) clears all valid bits and loads B with identity.
// A stalled result freezes the whole pipe; req_stall follows it in the same cycle.
`default_nettype none
module reflection_d_spacing_unit
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   req_valid,
    output logic                                        req_stall,
    input  wire logic signed [rds_pkg::INDEX_BITS-1:0]  index_h,
    input  wire logic signed [rds_pkg::INDEX_BITS-1:0]  index_k,
    input  wire logic signed [rds_pkg::INDEX_BITS-1:0]  index_l,
    output logic                                        rsp_valid,
    input  wire logic                                   rsp_stall,
    output logic [rds_pkg::ROOT_BITS-1:0]               recip_spacing,
    output logic [rds_pkg::ROOT_BITS-1:0]               spacing,
    output logic                                        spacing_invalid,
    input  wire logic                                   wr_en,
    input  wire logic [rds_pkg::IDX_W-1:0]              wr_index,
    input  wire logic [rds_pkg::REG_BITS-1:0]           wr_data
);

    rds_pkg::bmat_t     bmat_reg;
    rds_pkg::radicand_t rad;
    rds_pkg::root_t     root;
    logic               en;

    // pipe advances unless a finished beat is held at the output
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bmat_reg.b00 <= rds_pkg::ONE_Q2_30;
            bmat_reg.b01 <= '0;
            bmat_reg.b02 <= '0;
            bmat_reg.b11 <= rds_pkg::ONE_Q2_30;
            bmat_reg.b12 <= '0;
            bmat_reg.b22 <= rds_pkg::ONE_Q2_30;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rds_pkg::REG_B00: bmat_reg.b00 <= wr_data;
                rds_pkg::REG_B01: bmat_reg.b01 <= wr_data;
                rds_pkg::REG_B02: bmat_reg.b02 <= wr_data;
                rds_pkg::REG_B11: bmat_reg.b11 <= wr_data;
                rds_pkg::REG_B12: bmat_reg.b12 <= wr_data;
                rds_pkg::REG_B22: bmat_reg.b22 <= wr_data;
                default:          ;  // unmapped index: write dropped
            endcase
        end
    end

    // |B*hkl|^2 as Q.36 radicand plus overflow flag
    rds_sqsum u_sqsum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid   (req_valid && en),
        .index_h (index_h),
        .index_k (index_k),
        .index_l (index_l),
        .bmat    (bmat_reg),
        .rad     (rad)
    );

    // d* in Q14.18, saturated
    rds_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .rad   (rad),
        .root  (root)
    );

    // d = 2^38 / d*, last stage doubles as output register
    rds_div u_div
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .root            (root),
        .valid           (rsp_valid),
        .recip_spacing   (recip_spacing),
        .spacing         (spacing),
        .spacing_invalid (spacing_invalid)
    );

endmodule
`default_nettype wire

// ----- rtl/rds_checker.sv -----
`default_nettype none
module rds_checker
(
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   req_stall,
    input wire logic                                   rsp_valid,
    input wire logic                                   rsp_stall,
    input wire logic [rds_pkg::ROOT_BITS-1:0]          recip_spacing,
    input wire logic [rds_pkg::ROOT_BITS-1:0]          spacing,
    input wire logic                                   spacing_invalid
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(recip_spacing)
                                   && $stable(spacing) && $stable(spacing_invalid))
        else $error("stalled result changed");

    a_req_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled without output stall");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && spacing_invalid |-> spacing == rds_pkg::ALL_ONES)
        else $error("invalid spacing not saturated");

    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> spacing_invalid == (recip_spacing <= rds_pkg::MIN_RECIP))
        else $error("invalid flag disagrees with d star");

endmodule

bind reflection_d_spacing_unit rds_checker u_rds_checker (.*);
`default_nettype wire
